@@ sv/sidm_pkg.sv @@
// Shared types and constants for the sorted identifier list merge.
package sidm_pkg;

    localparam int LIST_DEPTH_DEF = 32;
    localparam int ID_W = 32;

    typedef struct packed {
        logic            list_select;
        logic [ID_W-1:0] row_id;
        logic            id_present;
        logic            list_end;
    } sidm_in_t;

    typedef struct packed {
        logic [ID_W-1:0] result_id;
        logic            is_empty;
        logic            overflowed;
        logic            last_result;
    } sidm_out_t;

    typedef enum logic [1:0] {
        S_LOAD,
        S_READ,
        S_CMP
    } sidm_state_t;

    localparam logic OP_INTERSECT = 1'b0;
    localparam logic OP_UNION     = 1'b1;

endpackage

@@ sv/sidm_store.sv @@
// Identifier store: one write port, one read port with registered read data.
module sidm_store
    import sidm_pkg::*;
#(
    parameter int DEPTH = LIST_DEPTH_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [ID_W-1:0]   wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [ID_W-1:0]   rd_data
);

    logic [ID_W-1:0] mem [DEPTH];
    logic [ID_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/sorted_id_list_merge.sv @@
// Top level of the sorted identifier list merge (intersection or union).
//
// Input channel s_valid/s_ready/s_data carries list items; each names the
// left or right list, an identifier, whether it holds a value and whether it
// ends that list. Loading takes one transfer per cycle into two stores of
// LIST_DEPTH words; elements beyond that depth are dropped and flagged.
// The transfer that ends the second list starts the merge: s_ready falls,
// the S_READ state primes the store reads, then the two-pointer walk, fed
// by the registered read of each store, takes at most left_count +
// right_count steps, and the finishing step moves the final result into
// the output register. Results leave on m_valid/m_ready/m_data in
// ascending order through an output register, one result held back so the
// final one carries last_result. An empty result gives one marker transfer.
// op_reg (cfg_wr_en/cfg_wr_data) selects intersect (0) or union (1).
// A stalled receiver holds the walk; loading resumes after the last result
// has entered the output register. Reset clears counts, pointers, end flags,
// the overflow flag and m_valid; store contents and m_data stay undefined.
module sorted_id_list_merge
    import sidm_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  sidm_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output sidm_out_t m_data,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data
);

    localparam int ADDR_W = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(LIST_DEPTH);

    sidm_state_t state_reg, state_next;

    logic             op_reg;
    logic [CNT_W-1:0] lcount_reg, lcount_next, rcount_reg, rcount_next;
    logic             ldone_reg, ldone_next, rdone_reg, rdone_next;
    logic             ovf_reg, ovf_next;
    logic [CNT_W-1:0] li_reg, li_next, ri_reg, ri_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [ID_W-1:0]  pend_id_reg, pend_id_next;
    logic             out_valid_reg, out_valid_next;
    sidm_out_t        out_data_reg, out_data_next;

    logic            s_fire, out_free, finish;
    logic            lwr_en, rwr_en;
    logic [ID_W-1:0] ldata, rdata;
    logic            lv, rv;

    sidm_store #(.DEPTH(LIST_DEPTH)) u_left (
        .aclk    (aclk),
        .wr_en   (lwr_en),
        .wr_addr (lcount_reg[ADDR_W-1:0]),
        .wr_data (s_data.row_id),
        .rd_addr (li_next[ADDR_W-1:0]),
        .rd_data (ldata)
    );

    sidm_store #(.DEPTH(LIST_DEPTH)) u_right (
        .aclk    (aclk),
        .wr_en   (rwr_en),
        .wr_addr (rcount_reg[ADDR_W-1:0]),
        .wr_data (s_data.row_id),
        .rd_addr (ri_next[ADDR_W-1:0]),
        .rd_data (rdata)
    );

    assign s_ready  = (state_reg == S_LOAD);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !out_valid_reg || m_ready;
    assign lv       = (li_reg < lcount_reg);
    assign rv       = (ri_reg < rcount_reg);
    assign finish   = (state_reg == S_CMP) && out_free &&
                      ((!lv && !rv) || ((op_reg == OP_INTERSECT) && (!lv || !rv)));

    assign lwr_en = s_fire && !s_data.list_select && !ldone_reg && s_data.id_present &&
                    (lcount_reg < DEPTH_C);
    assign rwr_en = s_fire && s_data.list_select && !rdone_reg && s_data.id_present &&
                    (rcount_reg < DEPTH_C);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD: begin
                if (ldone_next && rdone_next) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = S_CMP;
            end
            S_CMP: begin
                if (finish) begin
                    state_next = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_comb begin
        logic            emit;
        logic [ID_W-1:0] cand;
        logic            adv_l, adv_r;

        emit            = 1'b0;
        cand            = '0;
        adv_l           = 1'b0;
        adv_r           = 1'b0;
        lcount_next     = lcount_reg;
        rcount_next     = rcount_reg;
        ldone_next      = ldone_reg;
        rdone_next      = rdone_reg;
        ovf_next        = ovf_reg;
        li_next         = li_reg;
        ri_next         = ri_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_data_next   = out_data_reg;

        if (s_fire) begin
            if (!s_data.list_select && !ldone_reg) begin
                if (s_data.id_present) begin
                    if (lcount_reg < DEPTH_C) begin
                        lcount_next = lcount_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                ldone_next = ldone_reg || s_data.list_end;
            end
            if (s_data.list_select && !rdone_reg) begin
                if (s_data.id_present) begin
                    if (rcount_reg < DEPTH_C) begin
                        rcount_next = rcount_reg + 1'b1;
                    end else begin
                        ovf_next = 1'b1;
                    end
                end
                rdone_next = rdone_reg || s_data.list_end;
            end
        end

        if (state_reg == S_CMP) begin
            if (finish) begin
                out_valid_next            = 1'b1;
                out_data_next.result_id   = pend_valid_reg ? pend_id_reg : '0;
                out_data_next.is_empty    = !pend_valid_reg;
                out_data_next.overflowed  = ovf_reg;
                out_data_next.last_result = 1'b1;
                lcount_next     = '0;
                rcount_next     = '0;
                ldone_next      = 1'b0;
                rdone_next      = 1'b0;
                ovf_next        = 1'b0;
                li_next         = '0;
                ri_next         = '0;
                pend_valid_next = 1'b0;
            end else if (!(!lv && !rv) && !((op_reg == OP_INTERSECT) && (!lv || !rv))) begin
                if (lv && rv) begin
                    if (ldata == rdata) begin
                        emit  = 1'b1;
                        cand  = ldata;
                        adv_l = 1'b1;
                        adv_r = 1'b1;
                    end else if (ldata < rdata) begin
                        emit  = (op_reg == OP_UNION);
                        cand  = ldata;
                        adv_l = 1'b1;
                    end else begin
                        emit  = (op_reg == OP_UNION);
                        cand  = rdata;
                        adv_r = 1'b1;
                    end
                end else if (lv) begin
                    emit  = 1'b1;
                    cand  = ldata;
                    adv_l = 1'b1;
                end else begin
                    emit  = 1'b1;
                    cand  = rdata;
                    adv_r = 1'b1;
                end

                // hold the step while the held result cannot move on
                if (emit && pend_valid_reg && !out_free) begin
                    adv_l = 1'b0;
                    adv_r = 1'b0;
                end else if (emit) begin
                    if (pend_valid_reg) begin
                        out_valid_next            = 1'b1;
                        out_data_next.result_id   = pend_id_reg;
                        out_data_next.is_empty    = 1'b0;
                        out_data_next.overflowed  = ovf_reg;
                        out_data_next.last_result = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_id_next    = cand;
                end
                if (adv_l) begin
                    li_next = li_reg + 1'b1;
                end
                if (adv_r) begin
                    ri_next = ri_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_LOAD;
            op_reg         <= OP_INTERSECT;
            lcount_reg     <= '0;
            rcount_reg     <= '0;
            ldone_reg      <= 1'b0;
            rdone_reg      <= 1'b0;
            ovf_reg        <= 1'b0;
            li_reg         <= '0;
            ri_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            if (cfg_wr_en) begin
                op_reg <= cfg_wr_data;
            end
            lcount_reg     <= lcount_next;
            rcount_reg     <= rcount_next;
            ldone_reg      <= ldone_next;
            rdone_reg      <= rdone_next;
            ovf_reg        <= ovf_next;
            li_reg         <= li_next;
            ri_reg         <= ri_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_id_reg  <= pend_id_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_empty_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.is_empty) |-> m_data.last_result)
        else $error("empty marker without last_result");

    a_ptr_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CMP) |-> ((li_reg <= lcount_reg) && (ri_reg <= rcount_reg)))
        else $error("merge pointer beyond stored count");

    a_job_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        finish |=> ((lcount_reg == '0) && (rcount_reg == '0) && !ldone_reg && !rdone_reg
                    && !pend_valid_reg && m_valid && m_data.last_result))
        else $error("job state not cleared after final result");

    a_no_load_in_merge: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_LOAD) |-> (!lwr_en && !rwr_en))
        else $error("store write during merge");

endmodule
